// ===== src/cfc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types, constants and the byte-wide crc-32 update for the frame checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfc_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // crc-32, reflected form
  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFFFFFF;

  // hard limit on payload length
  localparam logic [LEN_W-1:0] MAX_PAYLOAD = 11'd1500;

  // register reset values
  localparam logic [WORD_W-1:0] MAGIC_RST   = 32'h49504657;
  localparam logic [BYTE_W-1:0] VERSION_RST = 8'h01;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST = 11'd1500;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MAGIC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_VERSION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY_LEN  = 2'd2;

  // header byte positions that trigger checks
  localparam logic [LEN_W-1:0] HDR_MAGIC_IDX   = 11'd3;
  localparam logic [LEN_W-1:0] HDR_VERSION_IDX = 11'd4;
  localparam logic [LEN_W-1:0] HDR_LENGTH_IDX  = 11'd7;
  localparam logic [LEN_W-1:0] CRC_BYTES       = 11'd4;

  // result kind
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // frame status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_MAGIC   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_VERSION = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_LENGTH  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_CRC     = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CRC,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [WORD_W-1:0] frame_magic;
    logic [BYTE_W-1:0] expected_version;
    logic [LEN_W-1:0]  max_payload_length;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0]    frame_length;
    logic [STATUS_W-1:0] frame_status;
    logic [BYTE_W-1:0]   payload_byte;
    logic                item_kind;
  } result_t;

  // one byte through the reflected crc-32
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/crc_frame_checker.sv =====
// Path: input request to result request through the input register and the result register.
// Throughput: one byte per cycle while the result side is not stalling; the parse step and
// byte-wide crc update sit between the input register and the result register.
// Bytes that cause no result still pass the parse step.
// Reset: synchronous active-low rst_n; registers return to their defaults,
// the parser goes idle until a transfer start.
// ----------------------------------------------------------------------------
// crc_frame_checker
// Byte-stream frame deframer: header checks, payload pass-through, crc-32 check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc_frame_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,  // [7:0] rx_byte
  input  wire logic                            in_tuser,  // [0] transfer_start
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [23:0]                          out_tdata, // [7:0] payload_byte,
                                                          // [10:8] frame_status,
                                                          // [21:11] frame_length
  output logic                                 out_tuser, // [0] item_kind
  input  wire logic                            cfg_we,
  input  wire logic [cfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cfc_pkg::WORD_W-1:0]      cfg_wdata
);
  import cfc_pkg::*;

  cfg_t        cfg_r;
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_start_r;
  logic        step;
  logic        load_ready;
  logic        res_valid;
  result_t     res;
  result_t     out_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_magic        <= MAGIC_RST;
      cfg_r.expected_version   <= VERSION_RST;
      cfg_r.max_payload_length <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_MAGIC: cfg_r.frame_magic        <= cfg_wdata;
        CFG_EXP_VERSION: cfg_r.expected_version   <= cfg_wdata[BYTE_W-1:0];
        CFG_MAX_PAY_LEN: cfg_r.max_payload_length <= cfg_wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  assign step      = in_valid_r && load_ready;
  assign in_tready = !in_valid_r || load_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  // parse step
  cfc_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (step),
    .rx_byte        (in_byte_r),
    .transfer_start (in_start_r),
    .cfg            (cfg_r),
    .res_valid      (res_valid),
    .res            (res)
  );

  // result register
  cfc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && res_valid),
    .load_data  (res),
    .load_ready (load_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_data)
  );

  assign out_tdata = {2'b00, out_data.frame_length, out_data.frame_status,
                      out_data.payload_byte};
  assign out_tuser = out_data.item_kind;

endmodule

`default_nettype wire

// ===== src/cfc_parser.sv =====
// ----------------------------------------------------------------------------
// cfc_parser
// Frame parse state, header checks and running crc; one byte per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfc_parser (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step_en,
  input  wire logic [7:0]             rx_byte,
  input  wire logic                   transfer_start,
  input  wire cfc_pkg::cfg_t          cfg,
  output logic                        res_valid,
  output cfc_pkg::result_t            res
);
  import cfc_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic [WORD_W-1:0] shift_r, shift_nxt;
  logic [LEN_W-1:0]  plen_r, plen_nxt;
  logic [WORD_W-1:0] crc_r, crc_nxt;
  logic [WORD_W-1:0] rcrc_r, rcrc_nxt;

  // state as seen after a transfer start
  phase_t            eff_phase;
  logic [LEN_W-1:0]  eff_count;
  logic [WORD_W-1:0] eff_shift;
  logic [LEN_W-1:0]  eff_plen;
  logic [WORD_W-1:0] eff_crc;
  logic [WORD_W-1:0] eff_rcrc;

  logic [WORD_W-1:0] shift_new;
  logic [WORD_W-1:0] rcrc_new;
  logic [WORD_W-1:0] crc_new;
  logic [LEN_W-1:0]  count_inc;
  logic [15:0]       len16;
  logic [LEN_W-1:0]  limit;
  logic              magic_bad;
  logic              ver_bad;
  logic              len_bad;
  logic              crc_ok;

  // a start byte restarts the frame
  always_comb begin
    eff_phase = transfer_start ? PH_HEADER : phase_r;
    eff_count = transfer_start ? '0 : count_r;
    eff_shift = transfer_start ? '0 : shift_r;
    eff_plen  = transfer_start ? '0 : plen_r;
    eff_crc   = transfer_start ? CRC_INIT : crc_r;
    eff_rcrc  = transfer_start ? '0 : rcrc_r;
  end

  // shared datapath
  assign shift_new = {eff_shift[23:0], rx_byte};
  assign rcrc_new  = {eff_rcrc[23:0], rx_byte};
  assign crc_new   = crc_byte(eff_crc, rx_byte);
  assign count_inc = eff_count + LEN_W'(1);
  assign len16     = shift_new[15:0];
  assign limit     = (cfg.max_payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                            : cfg.max_payload_length;
  assign magic_bad = (shift_new != cfg.frame_magic);
  assign ver_bad   = (rx_byte != cfg.expected_version);
  assign len_bad   = (len16 == 16'd0) || (len16 > {5'd0, limit});
  assign crc_ok    = (rcrc_new == ~eff_crc);

  // next state
  always_comb begin
    phase_nxt = eff_phase;
    count_nxt = eff_count;
    shift_nxt = eff_shift;
    plen_nxt  = eff_plen;
    crc_nxt   = eff_crc;
    rcrc_nxt  = eff_rcrc;
    case (eff_phase)
      PH_HEADER: begin
        shift_nxt = shift_new;
        count_nxt = count_inc;
        if (eff_count == HDR_MAGIC_IDX) begin
          if (magic_bad) phase_nxt = PH_DONE;
        end else if (eff_count == HDR_VERSION_IDX) begin
          if (ver_bad) phase_nxt = PH_DONE;
        end else if (eff_count == HDR_LENGTH_IDX) begin
          if (len_bad) begin
            phase_nxt = PH_DONE;
          end else begin
            plen_nxt  = len16[LEN_W-1:0];
            count_nxt = '0;
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        crc_nxt   = crc_new;
        count_nxt = count_inc;
        if (count_inc >= eff_plen) begin
          count_nxt = '0;
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        rcrc_nxt  = rcrc_new;
        count_nxt = count_inc;
        if (count_inc >= CRC_BYTES) phase_nxt = PH_DONE;
      end
      default: begin
      end
    endcase
  end

  // result for this byte
  always_comb begin
    res_valid        = 1'b0;
    res.item_kind    = KIND_STATUS;
    res.payload_byte = '0;
    res.frame_status = ST_OK;
    res.frame_length = '0;
    case (eff_phase)
      PH_HEADER: begin
        if (eff_count == HDR_MAGIC_IDX && magic_bad) begin
          res_valid        = 1'b1;
          res.frame_status = ST_BAD_MAGIC;
        end else if (eff_count == HDR_VERSION_IDX && ver_bad) begin
          res_valid        = 1'b1;
          res.frame_status = ST_BAD_VERSION;
        end else if (eff_count == HDR_LENGTH_IDX && len_bad) begin
          res_valid        = 1'b1;
          res.frame_status = ST_BAD_LENGTH;
        end
      end
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.item_kind    = KIND_PAYLOAD;
        res.payload_byte = rx_byte;
        res.frame_length = eff_plen;
      end
      PH_CRC: begin
        if (count_inc >= CRC_BYTES) begin
          res_valid        = 1'b1;
          res.frame_status = crc_ok ? ST_OK : ST_BAD_CRC;
          res.frame_length = eff_plen;
        end
      end
      default: begin
      end
    endcase
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      shift_r <= '0;
      plen_r  <= '0;
      crc_r   <= CRC_INIT;
      rcrc_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      shift_r <= shift_nxt;
      plen_r  <= plen_nxt;
      crc_r   <= crc_nxt;
      rcrc_r  <= rcrc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/cfc_out_reg.sv =====
// ----------------------------------------------------------------------------
// cfc_out_reg
// Result register holding one request toward the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfc_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire cfc_pkg::result_t  load_data,
  output logic                   load_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cfc_pkg::result_t       out_data
);
  import cfc_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  // slot is free when empty or being drained this cycle
  assign load_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_ready) valid_nxt = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load_ready && load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// ===== dv/crc_frame_checker_tb.sv =====
// ----------------------------------------------------------------------------
// crc_frame_checker_tb
// Self-checking bench for the byte-stream frame checker. A short table of
// hand-written frames runs first, then random traffic under several register
// settings. Every accepted byte goes through a software deframer that queues
// the results it should cause; each result request is compared field by field
// against the oldest queued entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_frame_checker_tb;
  import cfc_pkg::*;

  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 78;
  localparam int LONG_PHASE  = 1;
  localparam int IDLE_GAP    = 4;
  localparam int DRAIN_CYC   = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;

  typedef enum {ROW_PREDICT, ROW_NO_RESULT, ROW_TYPED} row_check_t;

  typedef enum {
    FR_GOOD, FR_BAD_CRC, FR_BAD_MAGIC, FR_BAD_VERSION, FR_BAD_LENGTH, FR_CUT, FR_NOISE
  } frame_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              start;
  } link_byte_t;

  typedef struct {
    link_byte_t  lb;
    row_check_t  check;
    result_t     typed;
  } dir_row_t;

  // dut signals
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic                 out_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_wdata = '0;

  // deframer model state and register copies
  phase_t            m_phase;
  logic [LEN_W-1:0]  m_count;
  logic [WORD_W-1:0] m_shift;
  logic [LEN_W-1:0]  m_len;
  logic [WORD_W-1:0] m_crc;
  logic [WORD_W-1:0] m_rx_crc;
  logic [WORD_W-1:0] cur_magic;
  logic [BYTE_W-1:0] cur_version;
  logic [LEN_W-1:0]  cur_max_len;

  result_t    frame_items_due[$];
  link_byte_t frame_q[$];
  dir_row_t   dir_rows[$];

  int cycle_count = 0;
  int fail_count = 0;
  int results_checked = 0;
  int bytes_taken = 0;
  int bytes_ignored = 0;
  int phase_items = 0;
  int tx_calm = 0;
  int rx_calm = 0;
  int rx_hold = 0;
  int status_tally [0:7] = '{default: 0};

  crc_frame_checker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // reflected crc-32, one bit per pass, data bit folded into the feedback
  function automatic logic [WORD_W-1:0] crc32_next(logic [WORD_W-1:0] acc,
                                                   logic [BYTE_W-1:0] data);
    logic [WORD_W-1:0] c;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ ({WORD_W{c[0] ^ data[i]}} & CRC_POLY);
    end
    return c;
  endfunction

  function automatic result_t mk_result(logic kind, logic [BYTE_W-1:0] b,
                                        logic [STATUS_W-1:0] st, logic [LEN_W-1:0] len);
    result_t r;
    r.item_kind    = kind;
    r.payload_byte = b;
    r.frame_status = st;
    r.frame_length = len;
    return r;
  endfunction

  // idle cycles per request, with occasional runs of back-to-back traffic
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(16, 64);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  // one byte through the deframer: header checks, payload echo, crc compare
  task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic start,
                              output logic has_item, output result_t item,
                              output logic taken);
    logic [LEN_W-1:0] idx;
    logic [LEN_W-1:0] lim;
    logic [15:0]      hdr_len;
    has_item = 1'b0;
    item     = '0;
    taken    = 1'b1;
    if (start) begin
      m_phase  = PH_HEADER;
      m_count  = '0;
      m_shift  = '0;
      m_len    = '0;
      m_crc    = CRC_INIT;
      m_rx_crc = '0;
    end
    case (m_phase)
      PH_HEADER: begin
        idx     = m_count;
        m_shift = {m_shift[23:0], b};
        m_count = m_count + LEN_W'(1);
        if (idx == HDR_MAGIC_IDX) begin
          if (m_shift != cur_magic) begin
            has_item = 1'b1;
            item     = mk_result(KIND_STATUS, 8'h00, ST_BAD_MAGIC, '0);
            m_phase  = PH_DONE;
          end
        end else if (idx == HDR_VERSION_IDX) begin
          if (b != cur_version) begin
            has_item = 1'b1;
            item     = mk_result(KIND_STATUS, 8'h00, ST_BAD_VERSION, '0);
            m_phase  = PH_DONE;
          end
        end else if (idx == HDR_LENGTH_IDX) begin
          hdr_len = m_shift[15:0];
          lim     = (cur_max_len > MAX_PAYLOAD) ? MAX_PAYLOAD : cur_max_len;
          if (hdr_len == 16'd0 || hdr_len > {5'd0, lim}) begin
            has_item = 1'b1;
            item     = mk_result(KIND_STATUS, 8'h00, ST_BAD_LENGTH, '0);
            m_phase  = PH_DONE;
          end else begin
            m_len   = hdr_len[LEN_W-1:0];
            m_count = '0;
            m_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        m_crc   = crc32_next(m_crc, b);
        m_count = m_count + LEN_W'(1);
        if (m_count >= m_len) begin
          m_count = '0;
          m_phase = PH_CRC;
        end
        has_item = 1'b1;
        item     = mk_result(KIND_PAYLOAD, b, ST_OK, m_len);
      end
      PH_CRC: begin
        m_rx_crc = {m_rx_crc[23:0], b};
        m_count  = m_count + LEN_W'(1);
        if (m_count >= CRC_BYTES) begin
          has_item = 1'b1;
          item     = mk_result(KIND_STATUS, 8'h00,
                               (m_rx_crc == ~m_crc) ? ST_OK : ST_BAD_CRC, m_len);
          m_phase  = PH_DONE;
        end
      end
      default: taken = 1'b0;
    endcase
  endtask

  // hand one byte to the block and wait for its request to be taken
  task automatic drive_byte(input logic [BYTE_W-1:0] data, input logic start);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (start || m_phase != PH_IDLE && m_phase != PH_DONE) bytes_taken++;
    else bytes_ignored++;
  endtask

  task automatic send_item(input link_byte_t lb);
    logic    has_item;
    logic    taken;
    result_t item;
    drive_byte(lb.data, lb.start);
    deframe_byte(lb.data, lb.start, has_item, item, taken);
    if (has_item) frame_items_due.push_back(item);
    if (taken) phase_items++;
  endtask

  task automatic send_queue();
    while (frame_q.size() != 0) send_item(frame_q.pop_front());
  endtask

  task automatic add_link(input logic [BYTE_W-1:0] data, input logic start);
    link_byte_t lb;
    lb.data  = data;
    lb.start = start;
    frame_q.push_back(lb);
  endtask

  // assemble one frame into frame_q under the current register settings
  task automatic build_frame(input frame_kind_t kind, input int unsigned force_len);
    int unsigned       lim;
    int unsigned       cap;
    int unsigned       plen;
    int unsigned       keep;
    logic [WORD_W-1:0] magic;
    logic [WORD_W-1:0] crc;
    logic [BYTE_W-1:0] ver;
    logic [BYTE_W-1:0] pb;
    logic [15:0]       hlen;
    frame_q.delete();
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 8))
        add_link(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return;
    end
    lim   = 32'((cur_max_len > MAX_PAYLOAD) ? MAX_PAYLOAD : cur_max_len);
    magic = cur_magic;
    ver   = cur_version;
    // mostly short payloads, a full-limit one only when the limit is small
    if (force_len != 0) begin
      plen = force_len;
    end else if (lim == 0) begin
      plen = $urandom_range(1, 8);
    end else begin
      cap = (lim < 16) ? lim : 16;
      case ($urandom_range(0, 9))
        0: plen = (lim <= 64) ? lim : cap;
        1: plen = 1;
        default: plen = $urandom_range(1, cap);
      endcase
    end
    hlen = plen[15:0];
    if (kind == FR_BAD_MAGIC) magic = magic ^ (32'd1 << $urandom_range(0, 31));
    if (kind == FR_BAD_VERSION) ver = ver ^ 8'($urandom_range(1, 255));
    if (kind == FR_BAD_LENGTH && force_len == 0) begin
      case ($urandom_range(0, 3))
        0: hlen = 16'h0000;
        1: hlen = 16'hFFFF;
        2: hlen = 16'(lim + 1);
        default: hlen = 16'($urandom_range(lim + 1, 65535));
      endcase
    end
    // header, big-endian magic and length
    add_link(magic[31:24], 1'b1);
    add_link(magic[23:16], 1'b0);
    add_link(magic[15:8], 1'b0);
    add_link(magic[7:0], 1'b0);
    add_link(ver, 1'b0);
    add_link(8'($urandom_range(0, 255)), 1'b0);
    add_link(hlen[15:8], 1'b0);
    add_link(hlen[7:0], 1'b0);
    if (kind != FR_BAD_LENGTH) begin
      crc = CRC_INIT;
      repeat (plen) begin
        pb  = 8'($urandom_range(0, 255));
        crc = crc32_next(crc, pb);
        add_link(pb, 1'b0);
      end
      crc = ~crc;
      if (kind == FR_BAD_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
      add_link(crc[31:24], 1'b0);
      add_link(crc[23:16], 1'b0);
      add_link(crc[15:8], 1'b0);
      add_link(crc[7:0], 1'b0);
    end
    // a cut frame is abandoned by whatever start follows
    if (kind == FR_CUT) begin
      keep = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > keep) void'(frame_q.pop_back());
      return;
    end
    // trailing bytes past the end of the frame
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) add_link(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return FR_GOOD;
    if (r < 65) return FR_BAD_CRC;
    if (r < 72) return FR_BAD_MAGIC;
    if (r < 79) return FR_BAD_VERSION;
    if (r < 87) return FR_BAD_LENGTH;
    if (r < 93) return FR_CUT;
    return FR_NOISE;
  endfunction

  // wait for the block to go quiet before touching registers
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (frame_items_due.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic program_regs(input logic [WORD_W-1:0] magic, input logic [BYTE_W-1:0] ver,
                              input logic [LEN_W-1:0] max_len);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_MAGIC;
    cfg_wdata <= magic;
    @(posedge clk);
    cfg_index <= CFG_EXP_VERSION;
    cfg_wdata <= {24'd0, ver};
    @(posedge clk);
    cfg_index <= CFG_MAX_PAY_LEN;
    cfg_wdata <= {21'd0, max_len};
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_magic   = magic;
    cur_version = ver;
    cur_max_len = max_len;
  endtask

  task automatic add_row(input logic [BYTE_W-1:0] data, input logic start,
                         input row_check_t check, input result_t typed);
    dir_row_t row;
    row.lb.data  = data;
    row.lb.start = start;
    row.check    = check;
    row.typed    = typed;
    dir_rows.push_back(row);
  endtask

  // compare one result request against the oldest expectation
  task automatic check_result(input logic kind, input logic [23:0] tdata);
    result_t exp_item;
    if (frame_items_due.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("unexpected result: kind %0d byte %02h status %0d len %0d",
                 kind, tdata[7:0], tdata[10:8], tdata[21:11]);
      return;
    end
    exp_item = frame_items_due.pop_front();
    results_checked++;
    if (exp_item.item_kind == KIND_STATUS) status_tally[exp_item.frame_status]++;
    if (kind !== exp_item.item_kind || tdata[7:0] !== exp_item.payload_byte ||
        tdata[10:8] !== exp_item.frame_status || tdata[21:11] !== exp_item.frame_length) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("mismatch at result %0d: expected kind %0d byte %02h status %0d len %0d, %s",
                 results_checked, exp_item.item_kind, exp_item.payload_byte,
                 exp_item.frame_status, exp_item.frame_length,
                 $sformatf("got kind %0d byte %02h status %0d len %0d",
                           kind, tdata[7:0], tdata[10:8], tdata[21:11]));
    end
  endtask

  // result side: check each request, then stall a random number of cycles
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      check_result(out_tuser, out_tdata);
      rx_hold = draw_gap(rx_calm);
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still owed",
             cycle_count, frame_items_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // main sequence
  initial begin
    logic              has_item;
    logic              taken;
    result_t           item;
    logic [WORD_W-1:0] ph_magic;
    logic [BYTE_W-1:0] ph_ver;
    logic [LEN_W-1:0]  ph_max;
    int                k;

    // model at its reset state
    m_phase     = PH_IDLE;
    m_count     = '0;
    m_shift     = '0;
    m_len       = '0;
    m_crc       = CRC_INIT;
    m_rx_crc    = '0;
    cur_magic   = MAGIC_RST;
    cur_version = VERSION_RST;
    cur_max_len = MAX_LEN_RST;

    // directed frames under reset settings (magic 49 50 46 57, version 1)
    add_row(8'h5A, 1'b0, ROW_NO_RESULT, '0);            // stray byte while idle
    add_row(8'h49, 1'b1, ROW_PREDICT, '0);              // wrong last magic byte
    add_row(8'h50, 1'b0, ROW_PREDICT, '0);
    add_row(8'h46, 1'b0, ROW_PREDICT, '0);
    add_row(8'h00, 1'b0, ROW_TYPED, mk_result(KIND_STATUS, 8'h00, ST_BAD_MAGIC, '0));
    add_row(8'h49, 1'b1, ROW_PREDICT, '0);              // wrong version
    add_row(8'h50, 1'b0, ROW_PREDICT, '0);
    add_row(8'h46, 1'b0, ROW_PREDICT, '0);
    add_row(8'h57, 1'b0, ROW_PREDICT, '0);
    add_row(8'hFF, 1'b0, ROW_TYPED, mk_result(KIND_STATUS, 8'h00, ST_BAD_VERSION, '0));
    add_row(8'h49, 1'b1, ROW_PREDICT, '0);              // one-byte payload ff, good crc
    add_row(8'h50, 1'b0, ROW_PREDICT, '0);
    add_row(8'h46, 1'b0, ROW_PREDICT, '0);
    add_row(8'h57, 1'b0, ROW_PREDICT, '0);
    add_row(8'h01, 1'b0, ROW_PREDICT, '0);
    add_row(8'hFF, 1'b0, ROW_PREDICT, '0);
    add_row(8'h00, 1'b0, ROW_PREDICT, '0);
    add_row(8'h01, 1'b0, ROW_PREDICT, '0);
    add_row(8'hFF, 1'b0, ROW_TYPED, mk_result(KIND_PAYLOAD, 8'hFF, ST_OK, 11'd1));
    add_row(8'hFF, 1'b0, ROW_PREDICT, '0);
    add_row(8'h00, 1'b0, ROW_PREDICT, '0);
    add_row(8'h00, 1'b0, ROW_PREDICT, '0);
    add_row(8'h00, 1'b0, ROW_TYPED, mk_result(KIND_STATUS, 8'h00, ST_OK, 11'd1));
    add_row(8'h00, 1'b0, ROW_NO_RESULT, '0);            // byte after the crc

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < dir_rows.size(); i++) begin
      drive_byte(dir_rows[i].lb.data, dir_rows[i].lb.start);
      deframe_byte(dir_rows[i].lb.data, dir_rows[i].lb.start, has_item, item, taken);
      case (dir_rows[i].check)
        ROW_PREDICT: if (has_item) frame_items_due.push_back(item);
        ROW_TYPED: frame_items_due.push_back(dir_rows[i].typed);
        default: ;
      endcase
    end

    // random phases, each under its own register setting
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          ph_magic = 32'h0000_0000;
          ph_ver   = 8'h00;
          ph_max   = 11'd1;
        end
        1: begin
          ph_magic = 32'hFFFF_FFFF;
          ph_ver   = 8'hFF;
          ph_max   = 11'd2047;
        end
        2: begin
          ph_magic = $urandom;
          ph_ver   = 8'($urandom_range(0, 255));
          ph_max   = 11'd0;
        end
        3: begin
          ph_magic = MAGIC_RST;
          ph_ver   = VERSION_RST;
          ph_max   = MAX_LEN_RST;
        end
        default: begin
          ph_magic = $urandom;
          ph_ver   = 8'($urandom_range(0, 255));
          ph_max   = 11'($urandom_range(2, 64));
        end
      endcase
      wait_idle();
      program_regs(ph_magic, ph_ver, ph_max);
      // finish a frame that was split across the register write
      send_queue();
      // one byte over the clamped limit while the register allows more
      if (p == LONG_PHASE) begin
        build_frame(FR_BAD_LENGTH, MAX_PAYLOAD + 1);
        send_queue();
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_frame(pick_kind(), 0);
        send_queue();
      end
      // sometimes leave a header half sent across the next register write
      if ($urandom_range(0, 1) == 1) begin
        build_frame(FR_GOOD, 0);
        k = $urandom_range(1, 7);
        repeat (k) send_item(frame_q.pop_front());
      end
    end
    send_queue();

    // drain
    wait_idle();
    repeat (DRAIN_CYC) @(posedge clk);
    if (frame_items_due.size() != 0) begin
      fail_count += frame_items_due.size();
      $display("%0d expected results never arrived", frame_items_due.size());
    end

    $display("covered %0d parsed bytes and %0d ignored bytes over %0d register settings, %s",
             bytes_taken, bytes_ignored, N_PHASES + 1,
             $sformatf("%0d results checked", results_checked));
    $display("frame endings: ok %0d, bad magic %0d, bad version %0d, bad length %0d, bad crc %0d",
             status_tally[ST_OK], status_tally[ST_BAD_MAGIC], status_tally[ST_BAD_VERSION],
             status_tally[ST_BAD_LENGTH], status_tally[ST_BAD_CRC]);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d failures found", fail_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
